// File: src/sqlx_pkg.sv
package sqlx_pkg;

  localparam int OffsetBitsDefault   = 32;
  localparam int PositionBitsDefault = 16;
  localparam int KeywordChars        = 8;
  localparam int KindBits            = 6;

  localparam logic [5:0] K_END     = 6'd0;
  localparam logic [5:0] K_IDENT   = 6'd1;
  localparam logic [5:0] K_KW0     = 6'd2;
  localparam logic [5:0] K_INT     = 6'd20;
  localparam logic [5:0] K_FLOAT   = 6'd21;
  localparam logic [5:0] K_STRING  = 6'd22;
  localparam logic [5:0] K_LPAREN  = 6'd23;
  localparam logic [5:0] K_RPAREN  = 6'd24;
  localparam logic [5:0] K_COMMA   = 6'd25;
  localparam logic [5:0] K_SEMI    = 6'd26;
  localparam logic [5:0] K_DOT     = 6'd27;
  localparam logic [5:0] K_EQ      = 6'd28;
  localparam logic [5:0] K_NE      = 6'd29;
  localparam logic [5:0] K_LT      = 6'd30;
  localparam logic [5:0] K_LE      = 6'd31;
  localparam logic [5:0] K_GT      = 6'd32;
  localparam logic [5:0] K_GE      = 6'd33;
  localparam logic [5:0] K_PLUS    = 6'd34;
  localparam logic [5:0] K_MINUS   = 6'd35;
  localparam logic [5:0] K_STAR    = 6'd36;
  localparam logic [5:0] K_SLASH   = 6'd37;
  localparam logic [5:0] K_INVALID = 6'd38;

  typedef struct packed {
    logic [7:0] char_byte;
    logic       is_end;
  } in_word_t;

  typedef struct packed {
    logic [5:0]  token_kind;
    logic [31:0] start_offset;
    logic [15:0] token_length;
    logic [15:0] start_line;
    logic [15:0] start_column;
    logic        last_of_run;
  } out_word_t;

  // Byte classes computed by the front stage.
  typedef struct packed {
    logic       is_end;
    logic [7:0] ch;
    logic       alpha;
    logic       digit;
    logic       space;
    logic       quote;
    logic       newline;
    logic [5:0] punct;
  } cls_t;

  localparam int KwCount = 18;
  typedef logic [63:0] kw_word_t;

  function automatic kw_word_t kw_pattern(input int i);
    unique case (i)
      0: kw_pattern = 64'h0000_4554_4145_5243; // CREATE
      1: kw_pattern = 64'h4553_4142_4154_4144; // DATABASE
      2: kw_pattern = 64'h0000_0000_0045_5355; // USE
      3: kw_pattern = 64'h0000_0045_4C42_4154; // TABLE
      4: kw_pattern = 64'h0000_0000_0054_4E49; // INT
      5: kw_pattern = 64'h0000_454C_4255_4F44; // DOUBLE
      6: kw_pattern = 64'h0052_4148_4352_4156; // VARCHAR
      7: kw_pattern = 64'h0000_5452_4553_4E49; // INSERT
      8: kw_pattern = 64'h0000_0000_4F54_4E49; // INTO
      9: kw_pattern = 64'h0000_5345_554C_4156; // VALUES
      10: kw_pattern = 64'h0000_5443_454C_4553; // SELECT
      11: kw_pattern = 64'h0000_4554_454C_4544; // DELETE
      12: kw_pattern = 64'h0000_4554_4144_5055; // UPDATE
      13: kw_pattern = 64'h0000_0000_0054_4553; // SET
      14: kw_pattern = 64'h0000_0000_4D4F_5246; // FROM
      15: kw_pattern = 64'h0000_0045_5245_4857; // WHERE
      16: kw_pattern = 64'h0000_0000_0044_4E41; // AND
      default: kw_pattern = 64'h0000_0000_0000_524F; // OR
    endcase
  endfunction

endpackage

// File: src/sqlx_front.sv
module sqlx_front (
  input  logic              clk,
  input  logic              rst,
  input  sqlx_pkg::in_word_t in_word,
  input  logic              in_valid,
  output logic              in_ready,
  output sqlx_pkg::cls_t    cls,
  output logic              cls_valid,
  input  logic              cls_ready
);

  sqlx_pkg::cls_t cls_next;
  logic [7:0]     c;

  assign in_ready = !cls_valid || cls_ready;
  assign c = in_word.char_byte;

  always_comb begin
    cls_next.is_end  = in_word.is_end;
    cls_next.ch      = c;
    cls_next.alpha   = (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A) || c == 8'h5F;
    cls_next.digit   = c >= 8'h30 && c <= 8'h39;
    cls_next.space   = c == 8'h20 || (c >= 8'h09 && c <= 8'h0D);
    cls_next.quote   = c == 8'h27;
    cls_next.newline = c == 8'h0A;
    unique case (c)
      8'h28: cls_next.punct = sqlx_pkg::K_LPAREN;
      8'h29: cls_next.punct = sqlx_pkg::K_RPAREN;
      8'h2C: cls_next.punct = sqlx_pkg::K_COMMA;
      8'h3B: cls_next.punct = sqlx_pkg::K_SEMI;
      8'h2E: cls_next.punct = sqlx_pkg::K_DOT;
      8'h3D: cls_next.punct = sqlx_pkg::K_EQ;
      8'h2B: cls_next.punct = sqlx_pkg::K_PLUS;
      8'h2D: cls_next.punct = sqlx_pkg::K_MINUS;
      8'h2A: cls_next.punct = sqlx_pkg::K_STAR;
      8'h2F: cls_next.punct = sqlx_pkg::K_SLASH;
      default: cls_next.punct = sqlx_pkg::K_INVALID;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cls_valid <= 1'b0;
    end else if (in_ready) begin
      cls_valid <= in_valid;
    end
    if (in_ready && in_valid) begin
      cls <= cls_next;
    end
  end

endmodule

// File: src/sqlx_fifo.sv
module sqlx_fifo #(
  parameter int Width = 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic [Width-1:0] wr_data,
  input  logic             wr_valid,
  output logic             wr_ready,
  output logic [Width-1:0] rd_data,
  output logic             rd_valid,
  input  logic             rd_ready
);

  logic [Width-1:0] mem [2];
  logic             wptr;
  logic             rptr;
  logic [1:0]       count;

  assign wr_ready = count != 2'd2;
  assign rd_valid = count != 2'd0;
  assign rd_data  = mem[rptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= 1'b0;
      rptr  <= 1'b0;
      count <= 2'd0;
    end else begin
      if (wr_valid && wr_ready) wptr <= !wptr;
      if (rd_valid && rd_ready) rptr <= !rptr;
      count <= count + {1'b0, wr_valid && wr_ready} - {1'b0, rd_valid && rd_ready};
    end
    if (wr_valid && wr_ready) mem[wptr] <= wr_data;
  end

endmodule

// File: src/sqlx_back.sv
module sqlx_back #(
  parameter int OffsetBits   = sqlx_pkg::OffsetBitsDefault,
  parameter int PositionBits = sqlx_pkg::PositionBitsDefault
) (
  input  logic               clk,
  input  logic               rst,
  input  sqlx_pkg::cls_t     cls,
  input  logic               cls_valid,
  output logic               cls_ready,
  output sqlx_pkg::out_word_t out_word,
  output logic               out_valid,
  input  logic               out_ready
);

  typedef enum logic [9:0] {
    M_IDLE     = 10'b00_0000_0001,
    M_IDENT    = 10'b00_0000_0010,
    M_INT      = 10'b00_0000_0100,
    M_INT_DOT  = 10'b00_0000_1000,
    M_FLOAT    = 10'b00_0001_0000,
    M_STRING   = 10'b00_0010_0000,
    M_STRING_Q = 10'b00_0100_0000,
    M_BANG     = 10'b00_1000_0000,
    M_LESS     = 10'b01_0000_0000,
    M_GREATER  = 10'b10_0000_0000
  } mode_t;

  localparam logic [15:0] LenMax = 16'hFFFF;
  localparam logic [PositionBits-1:0] PosMax = '1;
  localparam logic [PositionBits-1:0] PosOne = PositionBits'(1);

  typedef struct packed {
    logic [5:0]              kind;
    logic [OffsetBits-1:0]   off;
    logic [15:0]             len;
    logic [PositionBits-1:0] line;
    logic [PositionBits-1:0] col;
  } tok_t;

  mode_t mode, mode_next;
  logic [OffsetBits-1:0]   pos, tstart, dot_off;
  logic [PositionBits-1:0] line, col, tline, tcol, dot_line, dot_col;
  logic [15:0]             tbytes, tbytes_next;
  logic [63:0]             kwbuf, kwbuf_next;
  logic [3:0]              kwn, kwn_next;

  // Output slots: up to three tokens per byte, drained one a cycle while out_ready is high.
  tok_t       slot [3];
  tok_t       slot_next [3];
  logic [1:0] nslot, nslot_next;
  logic [1:0] rd, rd_next;
  logic       busy;

  logic [5:0]  ident_kind;
  logic [7:0]  up;
  logic [15:0] g1, g2;
  tok_t        pend, dot_tok;
  logic        absorbed;
  logic        do_tok;
  logic [5:0]  single_kind;

  assign busy      = rd != nslot;
  assign cls_ready = !busy || (rd == nslot - 2'd1 && out_ready);
  assign g1 = (tbytes == LenMax) ? LenMax : tbytes + 16'd1;
  assign g2 = (tbytes >= 16'hFFFE) ? LenMax : tbytes + 16'd2;

  always_comb begin
    ident_kind = sqlx_pkg::K_IDENT;
    if (kwn <= 4'd8) begin
      for (int i = sqlx_pkg::KwCount - 1; i >= 0; i--) begin
        if (kwbuf == sqlx_pkg::kw_pattern(i)) ident_kind = sqlx_pkg::K_KW0 + 6'(i);
      end
    end
  end

  assign up = (cls.ch >= 8'h61 && cls.ch <= 8'h7A) ? cls.ch - 8'd32 : cls.ch;

  always_comb begin
    pend    = '{kind: sqlx_pkg::K_END, off: tstart, len: tbytes, line: tline, col: tcol};
    dot_tok = '{kind: sqlx_pkg::K_DOT, off: dot_off, len: 16'd1, line: dot_line, col: dot_col};
    mode_next   = mode;
    tbytes_next = tbytes;
    kwbuf_next  = kwbuf;
    kwn_next    = kwn;
    nslot_next  = 2'd0;
    for (int i = 0; i < 3; i++) slot_next[i] = slot[i];
    absorbed    = 1'b0;
    do_tok      = 1'b0;
    single_kind = cls.punct;
    if (cls.is_end) begin
      unique case (mode)
        M_IDENT: begin pend.kind = ident_kind; do_tok = 1'b1; end
        M_INT: begin pend.kind = sqlx_pkg::K_INT; do_tok = 1'b1; end
        M_INT_DOT: begin
          pend.kind = sqlx_pkg::K_INT; do_tok = 1'b1;
        end
        M_FLOAT: begin pend.kind = sqlx_pkg::K_FLOAT; do_tok = 1'b1; end
        M_STRING: begin pend.kind = sqlx_pkg::K_INVALID; do_tok = 1'b1; end
        M_STRING_Q: begin pend.kind = sqlx_pkg::K_STRING; do_tok = 1'b1; end
        M_BANG: begin pend.kind = sqlx_pkg::K_INVALID; do_tok = 1'b1; end
        M_LESS: begin pend.kind = sqlx_pkg::K_LT; do_tok = 1'b1; end
        M_GREATER: begin pend.kind = sqlx_pkg::K_GT; do_tok = 1'b1; end
        default: ;
      endcase
      if (do_tok) begin
        slot_next[nslot_next] = pend;
        nslot_next = nslot_next + 2'd1;
      end
      if (mode == M_INT_DOT) begin
        slot_next[nslot_next] = dot_tok;
        nslot_next = nslot_next + 2'd1;
      end
      slot_next[nslot_next] = '{kind: sqlx_pkg::K_END, off: pos, len: 16'd0,
                                line: line, col: col};
      nslot_next = nslot_next + 2'd1;
      mode_next = M_IDLE;
    end else begin
      mode_next = M_IDLE;
      unique case (mode)
        M_IDENT:
          if (cls.alpha || cls.digit) begin
            absorbed = 1'b1; tbytes_next = g1; mode_next = M_IDENT;
            if (kwn < 4'd8) kwbuf_next = kwbuf | (64'(up) << {kwn[2:0], 3'b000});
            if (kwn <= 4'd8) kwn_next = kwn + 4'd1;
          end else begin pend.kind = ident_kind; do_tok = 1'b1; end
        M_INT:
          if (cls.digit) begin absorbed = 1'b1; tbytes_next = g1; mode_next = M_INT; end
          else if (cls.punct == sqlx_pkg::K_DOT) begin
            absorbed = 1'b1; mode_next = M_INT_DOT;
          end else begin pend.kind = sqlx_pkg::K_INT; do_tok = 1'b1; end
        M_INT_DOT:
          if (cls.digit) begin absorbed = 1'b1; tbytes_next = g2; mode_next = M_FLOAT; end
          else begin pend.kind = sqlx_pkg::K_INT; do_tok = 1'b1; end
        M_FLOAT:
          if (cls.digit) begin absorbed = 1'b1; tbytes_next = g1; mode_next = M_FLOAT; end
          else begin pend.kind = sqlx_pkg::K_FLOAT; do_tok = 1'b1; end
        M_STRING: begin
          absorbed = 1'b1; tbytes_next = g1;
          mode_next = cls.quote ? M_STRING_Q : M_STRING;
        end
        M_STRING_Q:
          if (cls.quote) begin absorbed = 1'b1; tbytes_next = g1; mode_next = M_STRING; end
          else begin pend.kind = sqlx_pkg::K_STRING; do_tok = 1'b1; end
        M_BANG:
          if (cls.ch == 8'h3D) begin
            absorbed = 1'b1; pend.len = g1; pend.kind = sqlx_pkg::K_NE; do_tok = 1'b1;
          end else begin pend.kind = sqlx_pkg::K_INVALID; do_tok = 1'b1; end
        M_LESS:
          if (cls.ch == 8'h3D || cls.ch == 8'h3E) begin
            absorbed = 1'b1; pend.len = g1; do_tok = 1'b1;
            pend.kind = (cls.ch == 8'h3D) ? sqlx_pkg::K_LE : sqlx_pkg::K_NE;
          end else begin pend.kind = sqlx_pkg::K_LT; do_tok = 1'b1; end
        M_GREATER:
          if (cls.ch == 8'h3D) begin
            absorbed = 1'b1; pend.len = g1; pend.kind = sqlx_pkg::K_GE; do_tok = 1'b1;
          end else begin pend.kind = sqlx_pkg::K_GT; do_tok = 1'b1; end
        default: ;
      endcase
      if (do_tok) begin
        slot_next[nslot_next] = pend;
        nslot_next = nslot_next + 2'd1;
      end
      if (mode == M_INT_DOT && !cls.digit) begin
        slot_next[nslot_next] = dot_tok;
        nslot_next = nslot_next + 2'd1;
      end
      if (!absorbed && !cls.space) begin
        tbytes_next = 16'd1;
        if (cls.alpha) begin
          mode_next  = M_IDENT;
          kwbuf_next = 64'(up);
          kwn_next   = 4'd1;
        end else if (cls.digit) mode_next = M_INT;
        else if (cls.quote) mode_next = M_STRING;
        else if (cls.ch == 8'h21) mode_next = M_BANG;
        else if (cls.ch == 8'h3C) mode_next = M_LESS;
        else if (cls.ch == 8'h3E) mode_next = M_GREATER;
        else begin
          slot_next[nslot_next] = '{kind: single_kind, off: pos, len: 16'd1,
                                    line: line, col: col};
          nslot_next = nslot_next + 2'd1;
        end
      end
    end
  end

  logic take;
  assign take = cls_valid && cls_ready;

  always_comb begin
    rd_next = rd;
    if (out_valid && out_ready) rd_next = rd + 2'd1;
    if (take) rd_next = 2'd0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode  <= M_IDLE;
      pos   <= '0;
      line  <= PosOne;
      col   <= PosOne;
      tstart <= '0;
      tline <= PosOne;
      tcol  <= PosOne;
      tbytes <= '0;
      kwbuf <= '0;
      kwn   <= '0;
      dot_off <= '0;
      dot_line <= PosOne;
      dot_col <= PosOne;
      nslot <= 2'd0;
      rd    <= 2'd0;
    end else begin
      rd <= rd_next;
      if (take) begin
        nslot <= nslot_next;
        for (int i = 0; i < 3; i++) slot[i] <= slot_next[i];
        if (cls.is_end) begin
          mode  <= M_IDLE;
          pos   <= '0;
          line  <= PosOne;
          col   <= PosOne;
          tstart <= '0;
          tline <= PosOne;
          tcol  <= PosOne;
          tbytes <= '0;
          kwbuf <= '0;
          kwn   <= '0;
          dot_off <= '0;
          dot_line <= PosOne;
          dot_col <= PosOne;
        end else begin
          mode   <= mode_next;
          tbytes <= tbytes_next;
          kwbuf  <= kwbuf_next;
          kwn    <= kwn_next;
          if (!absorbed && !cls.space) begin
            tstart <= pos;
            tline  <= line;
            tcol   <= col;
          end
          if (mode == M_INT && cls.punct == sqlx_pkg::K_DOT) begin
            dot_off  <= pos;
            dot_line <= line;
            dot_col  <= col;
          end
          pos <= pos + OffsetBits'(1);
          if (cls.newline) begin
            if (line != PosMax) line <= line + PosOne;
            col <= PosOne;
          end else if (col != PosMax) begin
            col <= col + PosOne;
          end
        end
      end
    end
  end

  assign out_valid = busy;
  always_comb begin
    out_word.token_kind   = slot[rd].kind;
    out_word.start_offset = 32'(slot[rd].off);
    out_word.token_length = slot[rd].len;
    out_word.start_line   = 16'(slot[rd].line);
    out_word.start_column = 16'(slot[rd].col);
    out_word.last_of_run  = rd == nslot - 2'd1;
  end

endmodule

// File: src/sql_token_lexer.sv
// Channel | Signals                       | Word
// in      | in_valid, in_ready, in_word   | sqlx_pkg::in_word_t
// out     | out_valid, out_ready, out_word | sqlx_pkg::out_word_t
//
// One byte per cycle is sustained when no byte yields more than one token and
// out_ready stays high. A byte yielding several tokens holds the back end
// while they drain. Bytes pass the classifier register and the two-entry
// queue before the back end's output slots. Reset clears all control state.
module sql_token_lexer #(
  parameter int OffsetBits   = sqlx_pkg::OffsetBitsDefault,
  parameter int PositionBits = sqlx_pkg::PositionBitsDefault
) (
  input  logic                clk,
  input  logic                rst,
  input  sqlx_pkg::in_word_t  in_word,
  input  logic                in_valid,
  output logic                in_ready,
  output sqlx_pkg::out_word_t out_word,
  output logic                out_valid,
  input  logic                out_ready
);

  sqlx_pkg::cls_t cls_f, cls_q;
  logic           f_valid, f_ready, q_valid, q_ready;

  sqlx_front u_front (
    .clk, .rst, .in_word, .in_valid, .in_ready,
    .cls(cls_f), .cls_valid(f_valid), .cls_ready(f_ready)
  );

  sqlx_fifo #(.Width($bits(sqlx_pkg::cls_t))) u_fifo (
    .clk, .rst,
    .wr_data(cls_f), .wr_valid(f_valid), .wr_ready(f_ready),
    .rd_data(cls_q), .rd_valid(q_valid), .rd_ready(q_ready)
  );

  sqlx_back #(.OffsetBits(OffsetBits), .PositionBits(PositionBits)) u_back (
    .clk, .rst, .cls(cls_q), .cls_valid(q_valid), .cls_ready(q_ready),
    .out_word, .out_valid, .out_ready
  );

endmodule

// File: src/sqlx_checker.sv
module sqlx_checker (
  input logic                clk,
  input logic                rst,
  input sqlx_pkg::out_word_t out_word,
  input logic                out_valid,
  input logic                out_ready
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_word))
    else $error("output word changed while stalled");

  a_kind_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_word.token_kind <= sqlx_pkg::K_INVALID)
    else $error("token kind out of range");

  a_end_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_word.token_kind == sqlx_pkg::K_END |-> out_word.last_of_run)
    else $error("end token not last");

  a_end_len: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_word.token_kind == sqlx_pkg::K_END |-> out_word.token_length == 16'd0)
    else $error("end token has length");

endmodule

bind sql_token_lexer sqlx_checker u_checker (.*);
